// ===== hw/rtl/css_color_string_parser_macros.svh =====
// Assertion macros for the CSS color string parser.
// Both macros expect signals named clk and rst_n in the scope of their use.
`ifndef CSS_COLOR_STRING_PARSER_MACROS_SVH
`define CSS_COLOR_STRING_PARSER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/css_pkg.sv =====
// Package for the CSS color string parser: parse phases, result type,
// character classes and the color name tables. No dependencies.
package css_pkg;

  typedef enum logic [3:0] {
    PH_WS,
    PH_HEX,
    PH_HEXEND,
    PH_WORD,
    PH_NAME,
    PH_RPRE,
    PH_RSIGN,
    PH_RDIG,
    PH_RPOST,
    PH_RDONE,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  localparam int NAME_COUNT = 17;
  localparam int NAME_TRANSPARENT = NAME_COUNT - 1;
  localparam int NAME_CHARS = 16;
  localparam logic [NAME_COUNT-1:0] ALL_NAMES = '1;
  localparam logic [3:0] POS_MAX = 4'd15;
  localparam logic [8:0] MAG_MAX = 9'd511;
  localparam logic [1:0] SLOT_LAST = 2'd2;
  localparam logic [2:0] HEX_LONG = 3'd6;
  localparam logic [2:0] HEX_SHORT = 3'd3;
  localparam logic [2:0] HEX_CNT_MAX = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam color_t COLOR_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - 8'h30;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] rgb_prefix_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = "r";
      2'd1:    ch = "g";
      2'd2:    ch = "b";
      default: ch = "(";
    endcase
    return ch;
  endfunction

  // Names are left aligned and padded with zero bytes to 16 characters.
  function automatic logic [8*NAME_CHARS-1:0] name_text(input int idx);
    logic [8*NAME_CHARS-1:0] t;
    case (idx)
      0:       t = {"black",       {11{8'h00}}};
      1:       t = {"white",       {11{8'h00}}};
      2:       t = {"red",         {13{8'h00}}};
      3:       t = {"green",       {11{8'h00}}};
      4:       t = {"blue",        {12{8'h00}}};
      5:       t = {"yellow",      {10{8'h00}}};
      6:       t = {"gray",        {12{8'h00}}};
      7:       t = {"grey",        {12{8'h00}}};
      8:       t = {"silver",      {10{8'h00}}};
      9:       t = {"orange",      {10{8'h00}}};
      10:      t = {"purple",      {10{8'h00}}};
      11:      t = {"navy",        {12{8'h00}}};
      12:      t = {"teal",        {12{8'h00}}};
      13:      t = {"maroon",      {10{8'h00}}};
      14:      t = {"aqua",        {12{8'h00}}};
      15:      t = {"lime",        {12{8'h00}}};
      default: t = {"transparent", {5{8'h00}}};
    endcase
    return t;
  endfunction

  function automatic logic [3:0] name_len(input int idx);
    logic [3:0] n;
    case (idx) inside
      2:                         n = 4'd3;
      4, 6, 7, 11, 12, 14, 15:   n = 4'd4;
      0, 1, 3:                   n = 4'd5;
      5, 8, 9, 10, 13:           n = 4'd6;
      default:                   n = 4'd11;
    endcase
    return n;
  endfunction

  function automatic logic [23:0] name_rgb(input int idx);
    logic [23:0] v;
    case (idx) inside
      0:       v = 24'h000000;
      1:       v = 24'hFFFFFF;
      2:       v = 24'hFF0000;
      3:       v = 24'h008000;
      4:       v = 24'h0000FF;
      5:       v = 24'hFFFF00;
      6, 7:    v = 24'h808080;
      8:       v = 24'hC0C0C0;
      9:       v = 24'hFFA500;
      10:      v = 24'h800080;
      11:      v = 24'h000080;
      12:      v = 24'h008080;
      13:      v = 24'h800000;
      14:      v = 24'h00FFFF;
      15:      v = 24'h00FF00;
      default: v = 24'h000000;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] take_digit(input logic [8:0] mag, input logic [7:0] c);
    logic [12:0] m;
    logic [7:0]  d;
    d = c - 8'h30;
    m = 13'(mag) * 13'd10 + 13'(d[3:0]);
    return (m > 13'(MAG_MAX)) ? MAG_MAX : m[8:0];
  endfunction

  function automatic logic [7:0] number_channel(input logic neg, input logic [8:0] mag);
    logic [7:0] ch;
    if (neg) begin
      ch = 8'd0;
    end else if (mag > 9'd255) begin
      ch = 8'd255;
    end else begin
      ch = mag[7:0];
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/css_in_if.sv =====
// Input channel of the CSS color string parser: one string byte per transaction.
// No dependencies.
interface css_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hw/rtl/css_out_if.sv =====
// Result channel of the CSS color string parser: one RGBA color per transaction.
// No dependencies.
interface css_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

// ===== hw/rtl/css_color_string_parser.sv =====
// CSS color string parser, top level.
// Depends on css_pkg, css_in_if, css_out_if and css_color_string_parser_macros.svh.
//
// Usage: the in_ch channel carries a color string one byte per transaction,
// with last_char set on its final byte. A zero byte ends the string early and
// the bytes after it are ignored until the last_char byte. The out_ch channel
// carries one RGBA color per string, for the transaction marked last_char.
// A string that does not parse gives opaque black.
// Throughput: one byte per cycle while in_ch.ready is high. The parse state
// is updated in the cycle a byte is accepted, and the color of a string is
// registered into the output register, or the skid entry if that is stalled.
// The result side has an output register and one skid entry, so bytes keep
// flowing while a color waits. When the receiver stalls with both entries
// full, in_ch.ready drops until the output register is taken.
// Reset (rst_n low, synchronous) empties both result entries and puts the
// parser back to the start of a string.
`include "css_color_string_parser_macros.svh"

module css_color_string_parser (
  input logic      clk,
  input logic      rst_n,
  css_in_if.sink   in_ch,
  css_out_if.source out_ch
);
  import css_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            hex_cnt_r, hex_cnt_nxt;
  logic [23:0]           hex_acc_r, hex_acc_nxt;
  logic [3:0]            pos_r, pos_nxt;
  logic                  exact_r, exact_nxt;
  logic [NAME_COUNT-1:0] cand_r, cand_nxt;
  logic [1:0]            slot_r, slot_nxt;
  logic                  neg_r, neg_nxt;
  logic [8:0]            mag_r, mag_nxt;
  logic [7:0]            first_r, first_nxt;
  logic [7:0]            second_r, second_nxt;
  logic                  ended_r, ended_nxt;

  color_t                result;
  color_t                out_data_r, skid_data_r;
  logic                  out_valid_r, skid_valid_r;

  logic [7:0]            c;
  logic [7:0]            lc;
  logic [7:0]            pc;
  logic                  in_accept;
  logic                  produce;
  logic                  out_open;
  logic [NAME_COUNT-1:0] name_hit;
  logic [NAME_COUNT-1:0] name_done;
  logic [6:0]            name_base;
  logic                  word_step;

  assign c         = in_ch.char_code;
  assign lc        = fold_lower(c);
  assign pc        = rgb_prefix_char(pos_r[1:0]);
  assign in_accept = in_ch.valid && in_ch.ready;
  assign produce   = in_accept && in_ch.last_char;
  assign in_ch.ready = !skid_valid_r;
  assign name_base = {4'(POS_MAX - pos_r), 3'b000};

  for (genvar gi = 0; gi < NAME_COUNT; gi++) begin : g_name
    localparam logic [8*NAME_CHARS-1:0] TEXT = name_text(gi);
    localparam logic [3:0]              LEN  = name_len(gi);
    assign name_hit[gi]  = (TEXT[name_base +: 8] == lc);
    assign name_done[gi] = cand_nxt[gi] && (pos_nxt == LEN);
  end

  // Next parse state for the byte on in_ch.
  always_comb begin
    phase_nxt  = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    pos_nxt    = pos_r;
    exact_nxt  = exact_r;
    cand_nxt   = cand_r;
    slot_nxt   = slot_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    ended_nxt  = ended_r;
    word_step  = 1'b0;
    if (!ended_r) begin
      if (c == CH_NUL) begin
        ended_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_WS: begin
            if (c == CH_HASH) begin
              phase_nxt = PH_HEX;
            end else if (!is_ws(c)) begin
              word_step = 1'b1;
            end
          end
          PH_WORD: begin
            word_step = 1'b1;
          end
          PH_NAME: begin
            cand_nxt = cand_r & name_hit;
            if (pos_r != POS_MAX) begin
              pos_nxt = pos_r + 4'd1;
            end
          end
          PH_HEX: begin
            if (!is_hex(c)) begin
              phase_nxt = PH_HEXEND;
            end else begin
              if (hex_cnt_r < HEX_LONG) begin
                hex_acc_nxt = {hex_acc_r[19:0], hex_nibble(c)};
              end
              if (hex_cnt_r != HEX_CNT_MAX) begin
                hex_cnt_nxt = hex_cnt_r + 3'd1;
              end
            end
          end
          PH_RPRE: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              neg_nxt   = (c == CH_MINUS);
              phase_nxt = PH_RSIGN;
            end else if (is_digit(c)) begin
              mag_nxt   = take_digit(mag_r, c);
              phase_nxt = PH_RDIG;
            end else if (!is_ws(c)) begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_RSIGN: begin
            if (is_digit(c)) begin
              mag_nxt   = take_digit(mag_r, c);
              phase_nxt = PH_RDIG;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_RDIG: begin
            if (is_digit(c)) begin
              mag_nxt = take_digit(mag_r, c);
            end else if (slot_r >= SLOT_LAST) begin
              phase_nxt = PH_RDONE;
            end else begin
              if (slot_r == 2'd0) begin
                first_nxt = number_channel(neg_r, mag_r);
              end else begin
                second_nxt = number_channel(neg_r, mag_r);
              end
              if (c == CH_COMMA) begin
                slot_nxt  = slot_r + 2'd1;
                neg_nxt   = 1'b0;
                mag_nxt   = '0;
                phase_nxt = PH_RPRE;
              end else begin
                phase_nxt = is_ws(c) ? PH_RPOST : PH_FAIL;
              end
            end
          end
          PH_RPOST: begin
            if (c == CH_COMMA) begin
              slot_nxt  = slot_r + 2'd1;
              neg_nxt   = 1'b0;
              mag_nxt   = '0;
              phase_nxt = PH_RPRE;
            end else if (!is_ws(c)) begin
              phase_nxt = PH_FAIL;
            end
          end
          default: begin
          end
        endcase
        if (word_step) begin
          cand_nxt = cand_r & name_hit;
          if (lc != pc) begin
            phase_nxt = PH_NAME;
          end else begin
            phase_nxt = PH_WORD;
            if (c != pc) begin
              exact_nxt = 1'b0;
            end
            if (pos_r == 4'd3) begin
              phase_nxt = exact_nxt ? PH_RPRE : PH_FAIL;
              neg_nxt   = 1'b0;
              mag_nxt   = '0;
            end
          end
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + 4'd1;
          end
        end
      end
    end
  end

  // Color of the string that ends with the byte on in_ch.
  always_comb begin
    result = COLOR_BLACK;
    unique case (phase_nxt) inside
      PH_HEX, PH_HEXEND: begin
        if (hex_cnt_nxt == HEX_LONG) begin
          result.red   = hex_acc_nxt[23:16];
          result.green = hex_acc_nxt[15:8];
          result.blue  = hex_acc_nxt[7:0];
        end else if (hex_cnt_nxt == HEX_SHORT) begin
          result.red   = {hex_acc_nxt[11:8], hex_acc_nxt[11:8]};
          result.green = {hex_acc_nxt[7:4], hex_acc_nxt[7:4]};
          result.blue  = {hex_acc_nxt[3:0], hex_acc_nxt[3:0]};
        end
      end
      PH_RDIG, PH_RDONE: begin
        if (phase_nxt == PH_RDONE || slot_nxt == SLOT_LAST) begin
          result.red   = first_nxt;
          result.green = second_nxt;
          result.blue  = number_channel(neg_nxt, mag_nxt);
        end
      end
      PH_WS, PH_WORD, PH_NAME: begin
        for (int i = NAME_COUNT - 1; i >= 0; i--) begin
          if (name_done[i]) begin
            {result.red, result.green, result.blue} = name_rgb(i);
            result.alpha = (i == NAME_TRANSPARENT) ? 8'd0 : 8'd255;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || produce) begin
      phase_r  <= PH_WS;
      hex_cnt_r <= '0;
      hex_acc_r <= '0;
      pos_r    <= '0;
      exact_r  <= 1'b1;
      cand_r   <= ALL_NAMES;
      slot_r   <= '0;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      ended_r  <= 1'b0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_acc_r <= hex_acc_nxt;
      pos_r    <= pos_nxt;
      exact_r  <= exact_nxt;
      cand_r   <= cand_nxt;
      slot_r   <= slot_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      ended_r  <= ended_nxt;
    end
  end

  assign out_open = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r  <= skid_valid_r || produce;
      skid_valid_r <= 1'b0;
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (produce) begin
      skid_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_data_r.red;
  assign out_ch.green = out_data_r.green;
  assign out_ch.blue  = out_data_r.blue;
  assign out_ch.alpha = out_data_r.alpha;

  `CSS_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r,
                   "Skid entry is full while the output register is empty.")
  `CSS_ASSERT_NEXT(a_last_gives_result, produce && !out_valid_r, out_valid_r,
                   "Last byte on an empty output did not give a result.")
  `CSS_ASSERT_NEXT(a_mid_no_result, in_accept && !in_ch.last_char && !out_valid_r,
                   !out_valid_r, "A byte before the last gave a result.")
  `CSS_ASSERT_NEXT(a_restart_after_last, produce,
                   phase_r == PH_WS && cand_r == ALL_NAMES && !ended_r,
                   "Parser did not return to the start of a string after the last byte.")

endmodule
